// ===== hdl/i2cd_pkg.sv =====
// i2cd_pkg: shared widths, codes and beat types for the I2C bus sample decoder.
// No dependencies; every other file refers to it by scoped names.
package i2cd_pkg;

  localparam int SAMPLE_W  = 8;
  localparam int TIME_W    = 32;
  localparam int BYTE_W    = 8;
  localparam int CNT_W     = 4;
  localparam int KIND_W    = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CNT_W-1:0] BYTE_BITS = 4'd8;

  localparam logic [SAMPLE_W-1:0] HIGH_RESET = 8'd192;
  localparam logic [SAMPLE_W-1:0] LOW_RESET  = 8'd64;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW  = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    EV_START = 3'd0,
    EV_ADDR  = 3'd1,
    EV_DATA  = 3'd2,
    EV_ACK   = 3'd3,
    EV_NAK   = 3'd4,
    EV_STOP  = 3'd5
  } ev_kind_t;

  // thresholded sample pair, stage 1 to decoder
  typedef struct packed {
    logic              sda;
    logic              scl;
    logic [TIME_W-1:0] sample_time;
  } level_beat_t;

  // one decoded bus event
  typedef struct packed {
    ev_kind_t          kind;
    logic [BYTE_W-1:0] byte_value;
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] end_time;
  } event_t;

endpackage

// ===== hdl/i2cd_in_if.sv =====
// i2cd_in_if: valid/ready channel carrying one SDA/SCL sample pair per beat.
// Depends on i2cd_pkg for field widths.
interface i2cd_in_if;
  logic                         valid;
  logic                         ready;
  logic [i2cd_pkg::SAMPLE_W-1:0] sda_sample;
  logic [i2cd_pkg::SAMPLE_W-1:0] scl_sample;
  logic [i2cd_pkg::TIME_W-1:0]   sample_time;

  modport source (output valid, sda_sample, scl_sample, sample_time, input ready);
  modport sink   (input valid, sda_sample, scl_sample, sample_time, output ready);
endinterface

// ===== hdl/i2cd_out_if.sv =====
// i2cd_out_if: valid/ready channel carrying one decoded bus event per beat.
// Depends on i2cd_pkg for field widths.
interface i2cd_out_if;
  logic                       valid;
  logic                       ready;
  logic [i2cd_pkg::KIND_W-1:0] event_kind;
  logic [i2cd_pkg::BYTE_W-1:0] byte_value;
  logic [i2cd_pkg::TIME_W-1:0] start_time;
  logic [i2cd_pkg::TIME_W-1:0] end_time;

  modport source (output valid, event_kind, byte_value, start_time, end_time, input ready);
  modport sink   (input valid, event_kind, byte_value, start_time, end_time, output ready);
endinterface

// ===== hdl/i2cd_level.sv =====
// i2cd_level: threshold registers, midpoint compare and the input beat register.
// Depends on i2cd_pkg.
module i2cd_level (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [i2cd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [i2cd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [i2cd_pkg::SAMPLE_W-1:0]   sda_sample,
  input  logic [i2cd_pkg::SAMPLE_W-1:0]   scl_sample,
  input  logic [i2cd_pkg::TIME_W-1:0]     sample_time,
  input  logic                            take,
  output logic                            lvl_valid,
  output i2cd_pkg::level_beat_t           lvl_beat
);

  logic [i2cd_pkg::SAMPLE_W-1:0] high_r;
  logic [i2cd_pkg::SAMPLE_W-1:0] low_r;
  logic [i2cd_pkg::SAMPLE_W:0]   sum;
  logic [i2cd_pkg::SAMPLE_W-1:0] mid;
  logic                          valid_r;
  logic                          valid_nxt;
  i2cd_pkg::level_beat_t         beat_r;
  logic                          in_fire;

  // 9-bit sum, floor of half
  assign sum = {1'b0, high_r} + {1'b0, low_r};
  assign mid = sum[i2cd_pkg::SAMPLE_W:1];

  assign in_ready  = !valid_r || take;
  assign in_fire   = in_valid && in_ready;
  assign valid_nxt = in_fire ? 1'b1 : (take ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_r  <= i2cd_pkg::HIGH_RESET;
      low_r   <= i2cd_pkg::LOW_RESET;
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (cfg_we && cfg_index == i2cd_pkg::CFG_HIGH) begin
        high_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == i2cd_pkg::CFG_LOW) begin
        low_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      beat_r.sda         <= sda_sample > mid;
      beat_r.scl         <= scl_sample > mid;
      beat_r.sample_time <= sample_time;
    end
  end

  assign lvl_valid = valid_r;
  assign lvl_beat  = beat_r;

endmodule

// ===== hdl/i2cd_decode.sv =====
// i2cd_decode: bus phase tracking, byte assembly and the result register.
// Depends on i2cd_pkg.
module i2cd_decode (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  lvl_valid,
  input  i2cd_pkg::level_beat_t lvl_beat,
  output logic                  take,
  output logic                  ev_valid,
  input  logic                  ev_ready,
  output i2cd_pkg::event_t      ev
);

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_ADDR     = 3'd1,
    PH_ADDR_ACK = 3'd2,
    PH_DATA     = 3'd3,
    PH_DATA_ACK = 3'd4
  } phase_t;

  phase_t                          phase_r, phase_nxt;
  logic                            prev_sda_r, prev_sda_nxt;
  logic                            prev_scl_r, prev_scl_nxt;
  logic                            have_prev_r, have_prev_nxt;
  logic [i2cd_pkg::BYTE_W-1:0]     shift_r, shift_nxt;
  logic [i2cd_pkg::CNT_W-1:0]      bits_r, bits_nxt;
  logic [i2cd_pkg::TIME_W-1:0]     begin_r, begin_nxt;
  logic                            mark_r, mark_nxt;
  logic                            ev_valid_r, ev_valid_nxt;
  i2cd_pkg::event_t                ev_r, ev_nxt;

  logic                            sda, scl;
  logic [i2cd_pkg::TIME_W-1:0]     t;
  logic                            start_c, stop_c, rise;
  logic [i2cd_pkg::BYTE_W-1:0]     shifted;
  logic [i2cd_pkg::CNT_W-1:0]      bits_inc;
  logic [i2cd_pkg::TIME_W-1:0]     begin_cur;
  logic                            fire;
  i2cd_pkg::event_t                new_ev;

  assign take = lvl_valid && (!ev_valid_r || ev_ready);

  assign sda      = lvl_beat.sda;
  assign scl      = lvl_beat.scl;
  assign t        = lvl_beat.sample_time;
  assign start_c  = prev_sda_r && !sda && scl;
  assign stop_c   = !prev_sda_r && sda && scl;
  assign rise     = !prev_scl_r && scl;
  assign shifted  = {shift_r[i2cd_pkg::BYTE_W-2:0], sda};
  assign bits_inc = bits_r + 1'b1;
  // data byte begins at the first sample after the acknowledge
  assign begin_cur = (phase_r == PH_DATA && mark_r) ? t : begin_r;

  always_comb begin
    phase_nxt     = phase_r;
    prev_sda_nxt  = prev_sda_r;
    prev_scl_nxt  = prev_scl_r;
    have_prev_nxt = have_prev_r;
    shift_nxt     = shift_r;
    bits_nxt      = bits_r;
    begin_nxt     = begin_r;
    mark_nxt      = mark_r;
    fire          = 1'b0;
    new_ev.kind       = i2cd_pkg::EV_START;
    new_ev.byte_value = '0;
    new_ev.start_time = t;
    new_ev.end_time   = t;

    if (take) begin
      prev_sda_nxt  = sda;
      prev_scl_nxt  = scl;
      have_prev_nxt = 1'b1;
      if (have_prev_r) begin
        case (phase_r)
          PH_ADDR, PH_ADDR_ACK, PH_DATA, PH_DATA_ACK: begin
            if (stop_c) begin
              fire        = 1'b1;
              new_ev.kind = i2cd_pkg::EV_STOP;
              phase_nxt   = PH_IDLE;
              shift_nxt   = '0;
              bits_nxt    = '0;
              mark_nxt    = 1'b0;
            end else if (start_c) begin
              // repeated START
              fire        = 1'b1;
              new_ev.kind = i2cd_pkg::EV_START;
              phase_nxt   = PH_ADDR;
              shift_nxt   = '0;
              bits_nxt    = '0;
              begin_nxt   = t;
              mark_nxt    = 1'b0;
            end else begin
              begin_nxt = begin_cur;
              if (phase_r == PH_DATA) begin
                mark_nxt = 1'b0;
              end
              if (rise) begin
                if (phase_r == PH_ADDR || phase_r == PH_DATA) begin
                  shift_nxt = shifted;
                  bits_nxt  = bits_inc;
                  if (bits_inc >= i2cd_pkg::BYTE_BITS) begin
                    fire              = 1'b1;
                    new_ev.kind       = (phase_r == PH_ADDR) ? i2cd_pkg::EV_ADDR
                                                             : i2cd_pkg::EV_DATA;
                    new_ev.byte_value = shifted;
                    new_ev.start_time = begin_cur;
                    phase_nxt         = (phase_r == PH_ADDR) ? PH_ADDR_ACK : PH_DATA_ACK;
                    bits_nxt          = '0;
                  end
                end else begin
                  // ninth clock: acknowledge slot
                  fire        = 1'b1;
                  new_ev.kind = sda ? i2cd_pkg::EV_NAK : i2cd_pkg::EV_ACK;
                  phase_nxt   = PH_DATA;
                  shift_nxt   = '0;
                  bits_nxt    = '0;
                  mark_nxt    = 1'b1;
                end
              end
            end
          end
          default: begin
            // idle, and any stray phase code
            phase_nxt = PH_IDLE;
            if (start_c) begin
              fire        = 1'b1;
              new_ev.kind = i2cd_pkg::EV_START;
              phase_nxt   = PH_ADDR;
              shift_nxt   = '0;
              bits_nxt    = '0;
              begin_nxt   = t;
              mark_nxt    = 1'b0;
            end
          end
        endcase
      end
    end

    if (take) begin
      ev_valid_nxt = fire;
    end else if (ev_ready) begin
      ev_valid_nxt = 1'b0;
    end else begin
      ev_valid_nxt = ev_valid_r;
    end
    ev_nxt = (take && fire) ? new_ev : ev_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      prev_sda_r  <= 1'b0;
      prev_scl_r  <= 1'b0;
      have_prev_r <= 1'b0;
      shift_r     <= '0;
      bits_r      <= '0;
      begin_r     <= '0;
      mark_r      <= 1'b0;
      ev_valid_r  <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      prev_sda_r  <= prev_sda_nxt;
      prev_scl_r  <= prev_scl_nxt;
      have_prev_r <= have_prev_nxt;
      shift_r     <= shift_nxt;
      bits_r      <= bits_nxt;
      begin_r     <= begin_nxt;
      mark_r      <= mark_nxt;
      ev_valid_r  <= ev_valid_nxt;
    end
    ev_r <= ev_nxt;
  end

  assign ev_valid = ev_valid_r;
  assign ev       = ev_r;

endmodule

// ===== hdl/i2c_bus_sample_decoder.sv =====
// i2c_bus_sample_decoder: top level of the sampled-line I2C decoder.
// Depends on i2cd_pkg, i2cd_in_if, i2cd_out_if, i2cd_level and i2cd_decode.
//
//  channel  | dir | handshake         | beat payload
//  ---------+-----+-------------------+------------------------------------------
//  in_ch    | in  | valid/ready       | sda_sample, scl_sample, sample_time
//  out_ch   | out | valid/ready       | event_kind, byte_value, start_time, end_time
//  cfg_*    | in  | cfg_we, no stall  | cfg_index (0 high, 1 low), cfg_wdata
//
// One beat a cycle in while in_ch.ready is high; a sample beat passes the input
// register, then the result register, before its event leaves.
// Decode state updates only as a beat moves from the input register into the
// result stage, so a stalled result holds the whole chain in place.
// With the result register full and stalled, one more beat is still taken
// into the input register; in_ch.ready drops only when both are occupied.
// Reset (rst_n low, synchronous) empties both stages, returns the bus to
// idle and reloads thresholds 192 and 64.
module i2c_bus_sample_decoder (
  input  logic                            clk,
  input  logic                            rst_n,
  i2cd_in_if.sink                         in_ch,
  i2cd_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [i2cd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [i2cd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic                  take;
  logic                  lvl_valid;
  i2cd_pkg::level_beat_t lvl_beat;
  logic                  ev_valid;
  i2cd_pkg::event_t      ev;

  // thresholding and input register
  i2cd_level u_level (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .sda_sample  (in_ch.sda_sample),
    .scl_sample  (in_ch.scl_sample),
    .sample_time (in_ch.sample_time),
    .take        (take),
    .lvl_valid   (lvl_valid),
    .lvl_beat    (lvl_beat)
  );

  // protocol tracking and result register
  i2cd_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .lvl_valid (lvl_valid),
    .lvl_beat  (lvl_beat),
    .take      (take),
    .ev_valid  (ev_valid),
    .ev_ready  (out_ch.ready),
    .ev        (ev)
  );

  assign out_ch.valid      = ev_valid;
  assign out_ch.event_kind = ev.kind;
  assign out_ch.byte_value = ev.byte_value;
  assign out_ch.start_time = ev.start_time;
  assign out_ch.end_time   = ev.end_time;

endmodule

// ===== hdl/i2cd_checker.sv =====
// i2cd_checker: port-level assertions for the I2C bus sample decoder.
// Depends on i2cd_pkg; bound to i2c_bus_sample_decoder at the end of this file.
module i2cd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [i2cd_pkg::KIND_W-1:0] event_kind,
  input logic [i2cd_pkg::BYTE_W-1:0] byte_value,
  input logic [i2cd_pkg::TIME_W-1:0] start_time,
  input logic [i2cd_pkg::TIME_W-1:0] end_time
);

  // a stalled event stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("event dropped while stalled");

  // reset leaves the result stage empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("event offered right after reset");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> event_kind <= i2cd_pkg::EV_STOP)
    else $error("undefined event kind");

  // only byte events carry a value and a span
  a_point_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && event_kind != i2cd_pkg::EV_ADDR && event_kind != i2cd_pkg::EV_DATA
    |-> byte_value == '0 && start_time == end_time)
    else $error("non-byte event with value or span");

endmodule

bind i2c_bus_sample_decoder i2cd_checker u_i2cd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .event_kind (out_ch.event_kind),
  .byte_value (out_ch.byte_value),
  .start_time (out_ch.start_time),
  .end_time   (out_ch.end_time)
);
